// File: rtl/core/cswb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswb_pkg: shared definitions for the color sensor white balance block
// Holds widths, phase codes, filter codes and the structs between modules.
// ----------------------------------------------------------------------------
package cswb_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int WIN_WIDTH   = 16;
    localparam int DIV_W       = COUNT_WIDTH + 8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};
    localparam logic [7:0]             FULL_SCALE   = 8'd255;
    localparam logic [WIN_WIDTH-1:0]   WINDOW_RESET = 16'd10000;
    localparam logic [3:0]             DIV_STEPS    = 4'd8;

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_BAL_R  = 3'd1;
    localparam logic [2:0] PH_BAL_G  = 3'd2;
    localparam logic [2:0] PH_BAL_B  = 3'd3;
    localparam logic [2:0] PH_MEAS_R = 3'd4;
    localparam logic [2:0] PH_MEAS_G = 3'd5;
    localparam logic [2:0] PH_MEAS_B = 3'd6;

    // Commands.
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_BALANCE  = 2'd1;
    localparam logic [1:0] ACT_MEASURE  = 2'd2;
    localparam logic [1:0] ACT_BAL_MEAS = 2'd3;

    // Filter pin codes {s2,s3}.
    localparam logic [1:0] FSEL_RED   = 2'd0;
    localparam logic [1:0] FSEL_BLUE  = 2'd1;
    localparam logic [1:0] FSEL_OFF   = 2'd2;
    localparam logic [1:0] FSEL_GREEN = 2'd3;

    localparam logic KIND_BALANCE = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

    typedef struct packed {
        logic                   start;
        logic [DIV_W-1:0]       num;
        logic [COUNT_WIDTH-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic       fault;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       kind;
        logic       done;
        logic       busy;
        logic [1:0] fsel;
    } t_result;

    function automatic logic [1:0] phase_fsel(input logic [2:0] phase);
        logic [1:0] f;
        unique case (phase)
            PH_BAL_R, PH_MEAS_R: f = FSEL_RED;
            PH_BAL_G, PH_MEAS_G: f = FSEL_GREEN;
            PH_BAL_B, PH_MEAS_B: f = FSEL_BLUE;
            default:             f = FSEL_OFF;
        endcase
        return f;
    endfunction

endpackage

// File: rtl/core/color_sensor_white_balance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_sensor_white_balance: color counter with white balance, top level
// Each input beat is one sample tick of the sensor output plus a command.
// Each accepted beat produces exactly one output beat with the filter select,
// sequence status and the last normalized red, green and blue readings.
// Configuration: i_cfg_we writes i_cfg_wdata as the window length in ticks;
// write it only while no sequence runs and no beat is in flight.
// The output beat passes through the sequencer's emit register and then the
// output register; when the beat closes a measurement window with a nonzero
// gain, the normalizing division first runs through the shared compare and
// subtract unit, one quotient bit per cycle over nine steps.
// No new input beat is accepted while the last beat's result is still pending.
// Reset clears all counters, gains and readings; the window length returns to
// 10000 ticks and the sensor is assumed idle high.
// When the receiver stalls, the output register holds its beat and no new
// input beat is accepted until that beat is taken.
// ----------------------------------------------------------------------------
module color_sensor_white_balance
    import cswb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WIN_WIDTH-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [1:0] action, [2] sensor_level, rest zero
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] filter_select, [2] busy_res, [3] done_res, [4] done_kind,
    // [12:5] red_value, [20:13] green_value, [28:21] blue_value, [29] zero_gain
    output logic [31:0]          m_axis_tdata
);

    logic [WIN_WIDTH-1:0] r_window_ticks;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;
    logic                 step;
    logic                 seq_busy;
    logic                 res_valid;
    t_result              res;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    assign s_axis_tready = !seq_busy && (!r_out_valid || m_axis_tready);
    assign step          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_ticks <= i_cfg_wdata;
        end
    end

    cswb_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_action       (s_axis_tdata[1:0]),
        .i_level        (s_axis_tdata[2]),
        .i_window_ticks (r_window_ticks),
        .i_div          (div_rsp),
        .o_div          (div_req),
        .o_busy         (seq_busy),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    cswb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out_data <= {2'b00, res.fault, res.blue, res.green, res.red,
                           res.kind, res.done, res.busy, res.fsel};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !r_out_valid)
        else $error("result arrived while output beat still pending");
`endif

endmodule

// File: rtl/core/cswb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswb_div: iterative saturating divider
// Restoring division, one compare and subtract per cycle, quotient capped at 255.
// ----------------------------------------------------------------------------
module cswb_div
    import cswb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [3:0]       r_cnt, n_cnt;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dsh, n_dsh;
    logic [7:0]       r_q, n_q;
    logic             r_sat, n_sat;
    logic             ge;
    logic [DIV_W-1:0] diff;

    // The shared unit: one wide compare and subtract.
    assign ge   = (r_rem >= r_dsh);
    assign diff = r_rem - r_dsh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_sat  = r_sat;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_STEPS;
            n_rem  = i_req.num;
            n_dsh  = {i_req.den, 8'd0};
            n_q    = 8'd0;
            n_sat  = 1'b0;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = diff;
            end
            // A set bit at weight 256 means the quotient exceeds full scale.
            if (r_cnt == DIV_STEPS) begin
                n_sat = ge;
            end else begin
                n_q = {r_q[6:0], ge};
            end
            n_dsh = r_dsh >> 1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
        r_sat <= n_sat;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sat ? FULL_SCALE : r_q;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= DIV_STEPS))
        else $error("divider step counter out of range");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still iterating");
`endif

endmodule

// File: rtl/core/cswb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswb_seq: window counting and channel sequencer
// Counts falling edges per window, steps the filter and drives the divider.
// ----------------------------------------------------------------------------
module cswb_seq
    import cswb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [1:0]           i_action,
    input  logic                 i_level,
    input  logic [WIN_WIDTH-1:0] i_window_ticks,
    input  t_div_rsp             i_div,
    output t_div_req             o_div,
    output logic                 o_busy,
    output logic                 o_res_valid,
    output t_result              o_res
);

    logic [2:0]             r_phase, n_phase;
    logic                   r_mab, n_mab;
    logic [COUNT_WIDTH-1:0] r_edge, n_edge;
    logic [WIN_WIDTH-1:0]   r_win, n_win;
    logic                   r_prev, n_prev;
    logic [COUNT_WIDTH-1:0] r_gain [3];
    logic [COUNT_WIDTH-1:0] n_gain [3];
    logic [7:0]             r_value [3];
    logic [7:0]             n_value [3];
    logic                   r_fault, n_fault;
    logic                   r_done, n_done;
    logic                   r_kind, n_kind;
    logic                   r_emit, n_emit;
    logic                   r_wait, n_wait;
    logic [1:0]             r_div_ch, n_div_ch;

    logic                   falling;
    logic [COUNT_WIDTH-1:0] edge_inc;
    logic [WIN_WIDTH-1:0]   win_inc;
    logic [1:0]             ch;

    assign falling  = r_prev & ~i_level;
    assign edge_inc = (falling && (r_edge != COUNT_MAX)) ? r_edge + 1'b1 : r_edge;
    assign win_inc  = r_win + 1'b1;
    assign ch       = (r_phase <= PH_BAL_B) ? 2'(r_phase - PH_BAL_R)
                                            : 2'(r_phase - PH_MEAS_R);

    always_comb begin
        n_phase  = r_phase;
        n_mab    = r_mab;
        n_edge   = r_edge;
        n_win    = r_win;
        n_prev   = r_prev;
        n_gain   = r_gain;
        n_value  = r_value;
        n_fault  = r_fault;
        n_done   = r_done;
        n_kind   = r_kind;
        n_emit   = 1'b0;
        n_wait   = r_wait;
        n_div_ch = r_div_ch;
        o_div.start = 1'b0;
        o_div.num   = ({edge_inc, 8'd0}) - DIV_W'(edge_inc);
        o_div.den   = r_gain[ch];

        if (i_step) begin
            n_prev = i_level;
            n_done = 1'b0;
            n_kind = KIND_BALANCE;
            n_emit = 1'b1;
            if (r_phase == PH_IDLE) begin
                if (i_action != ACT_NONE) begin
                    n_edge = '0;
                    n_win  = '0;
                    if (i_action == ACT_MEASURE) begin
                        n_phase = PH_MEAS_R;
                        n_fault = 1'b0;
                    end else begin
                        n_phase = PH_BAL_R;
                        n_mab   = (i_action == ACT_BAL_MEAS);
                    end
                end
            end else if (r_phase <= PH_MEAS_B) begin
                n_edge = edge_inc;
                n_win  = win_inc;
                // A window length of zero ends every window after one tick.
                if (win_inc >= i_window_ticks) begin
                    if (r_phase <= PH_BAL_B) begin
                        n_gain[ch] = edge_inc;
                    end else if (r_gain[ch] == '0) begin
                        n_value[ch] = FULL_SCALE;
                        n_fault     = 1'b1;
                    end else begin
                        // The result waits for the divider to finish.
                        o_div.start = 1'b1;
                        n_wait      = 1'b1;
                        n_emit      = 1'b0;
                        n_div_ch    = ch;
                    end
                    n_edge = '0;
                    n_win  = '0;
                    if (r_phase == PH_BAL_B) begin
                        n_done = 1'b1;
                        n_kind = KIND_BALANCE;
                        if (r_mab) begin
                            n_phase = PH_MEAS_R;
                            n_fault = 1'b0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                        n_mab = 1'b0;
                    end else if (r_phase == PH_MEAS_B) begin
                        n_done  = 1'b1;
                        n_kind  = KIND_MEASURE;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = r_phase + 3'd1;
                    end
                end
            end else begin
                n_phase = PH_IDLE;
            end
        end else if (r_wait && i_div.done) begin
            n_value[r_div_ch] = i_div.quot;
            n_wait            = 1'b0;
            n_emit            = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_mab    <= 1'b0;
            r_edge   <= '0;
            r_win    <= '0;
            r_prev   <= 1'b1;
            r_gain   <= '{default: '0};
            r_value  <= '{default: '0};
            r_fault  <= 1'b0;
            r_done   <= 1'b0;
            r_kind   <= KIND_BALANCE;
            r_emit   <= 1'b0;
            r_wait   <= 1'b0;
            r_div_ch <= 2'd0;
        end else begin
            r_phase  <= n_phase;
            r_mab    <= n_mab;
            r_edge   <= n_edge;
            r_win    <= n_win;
            r_prev   <= n_prev;
            r_gain   <= n_gain;
            r_value  <= n_value;
            r_fault  <= n_fault;
            r_done   <= n_done;
            r_kind   <= n_kind;
            r_emit   <= n_emit;
            r_wait   <= n_wait;
            r_div_ch <= n_div_ch;
        end
    end

    assign o_busy      = r_emit | r_wait;
    assign o_res_valid = r_emit;

    assign o_res.fsel  = phase_fsel(r_phase);
    assign o_res.busy  = (r_phase != PH_IDLE);
    assign o_res.done  = r_done;
    assign o_res.kind  = r_kind;
    assign o_res.red   = r_value[0];
    assign o_res.green = r_value[1];
    assign o_res.blue  = r_value[2];
    assign o_res.fault = r_fault;

`ifndef SYNTH
    a_step_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_emit || r_wait))
        else $error("accepted beat produced neither a result nor a division");
    a_kind_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit && !r_done) |-> (r_kind == KIND_BALANCE))
        else $error("completion kind set without completion");
    a_busy_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> (o_res.busy == (o_res.fsel != FSEL_OFF)))
        else $error("busy flag disagrees with filter selection");
`endif

endmodule

// File: tb/sv/cswb_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswb_status_checker: output predictor and comparator for the color counter
// Follows window writes and every accepted input beat, predicts the status
// beat that each one produces, and compares the output beats in order.
// ----------------------------------------------------------------------------
module cswb_status_checker
    import cswb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WIN_WIDTH-1:0] i_cfg_wdata,
    input  logic                 i_s_valid,
    input  logic                 i_s_ready,
    input  logic [7:0]           i_s_data,  // [1:0] action, [2] sensor_level
    input  logic                 i_m_valid,
    input  logic                 i_m_ready,
    input  logic [31:0]          i_m_data,  // packed t_result, [31:30] zero
    output int                   o_pending,
    output int                   o_fail_count
);

    t_result                expected_status[$];
    int                     n_fail = 0;

    // Shadow of the block's sequencer and stored readings.
    logic [WIN_WIDTH-1:0]   win_len;
    logic [2:0]             seq_phase;
    logic                   chain_measure;
    logic [COUNT_WIDTH-1:0] edges;
    logic [WIN_WIDTH:0]     ticks;
    logic                   last_level;
    logic [COUNT_WIDTH-1:0] gain [3];
    logic [7:0]             reading [3];
    logic                   fault;

    assign o_fail_count = n_fail;

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : predict_status
        t_result     want;
        t_result     got;
        logic [1:0]  act;
        logic        lvl;
        logic        fell;
        int unsigned ch;
        int unsigned quot;
        if (!i_rst_n) begin
            expected_status.delete();
            win_len       = WINDOW_RESET;
            seq_phase     = PH_IDLE;
            chain_measure = 1'b0;
            edges         = '0;
            ticks         = '0;
            last_level    = 1'b1;
            fault         = 1'b0;
            for (int i = 0; i < 3; i++) begin
                gain[i]    = '0;
                reading[i] = '0;
            end
        end else begin
            if (i_cfg_we)
                win_len = i_cfg_wdata;

            // An output beat always trails its input beat through registers, so pop before push.
            if (i_m_valid && i_m_ready) begin
                got = t_result'(i_m_data[29:0]);
                if (expected_status.size() == 0) begin
                    $error("output beat with no expected status waiting");
                    n_fail++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("filter_select", want.fsel, got.fsel);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("done_res", want.done, got.done);
                    check_field("done_kind", want.kind, got.kind);
                    check_field("red_value", want.red, got.red);
                    check_field("green_value", want.green, got.green);
                    check_field("blue_value", want.blue, got.blue);
                    check_field("zero_gain", want.fault, got.fault);
                end
            end

            if (i_s_valid && i_s_ready) begin
                act        = i_s_data[1:0];
                lvl        = i_s_data[2];
                fell       = last_level && !lvl;
                last_level = lvl;
                want       = '0;

                if (seq_phase == PH_IDLE) begin
                    // The start tick itself never counts an edge.
                    if (act != ACT_NONE) begin
                        edges = '0;
                        ticks = '0;
                        if (act == ACT_MEASURE) begin
                            seq_phase = PH_MEAS_R;
                            fault     = 1'b0;
                        end else begin
                            seq_phase     = PH_BAL_R;
                            chain_measure = (act == ACT_BAL_MEAS);
                        end
                    end
                end else if (seq_phase <= PH_MEAS_B) begin
                    if (fell && edges != COUNT_MAX)
                        edges++;
                    ticks++;
                    // A window length of zero closes every tick, like one.
                    if (ticks >= win_len) begin
                        if (seq_phase <= PH_BAL_B) begin
                            gain[seq_phase - PH_BAL_R] = edges;
                        end else begin
                            ch = seq_phase - PH_MEAS_R;
                            if (gain[ch] == 0) begin
                                reading[ch] = FULL_SCALE;
                                fault       = 1'b1;
                            end else begin
                                quot = (32'(edges) * 32'd255) / 32'(gain[ch]);
                                reading[ch] = (quot > 255) ? FULL_SCALE : quot[7:0];
                            end
                        end
                        edges = '0;
                        ticks = '0;
                        if (seq_phase == PH_BAL_B) begin
                            want.done = 1'b1;
                            want.kind = KIND_BALANCE;
                            if (chain_measure) begin
                                seq_phase = PH_MEAS_R;
                                fault     = 1'b0;
                            end else begin
                                seq_phase = PH_IDLE;
                            end
                            chain_measure = 1'b0;
                        end else if (seq_phase == PH_MEAS_B) begin
                            want.done = 1'b1;
                            want.kind = KIND_MEASURE;
                            seq_phase = PH_IDLE;
                        end else begin
                            seq_phase++;
                        end
                    end
                end else begin
                    seq_phase = PH_IDLE;
                end

                case (seq_phase)
                    PH_BAL_R, PH_MEAS_R: want.fsel = FSEL_RED;
                    PH_BAL_G, PH_MEAS_G: want.fsel = FSEL_GREEN;
                    PH_BAL_B, PH_MEAS_B: want.fsel = FSEL_BLUE;
                    default:             want.fsel = FSEL_OFF;
                endcase
                want.busy  = (seq_phase != PH_IDLE);
                want.red   = reading[0];
                want.green = reading[1];
                want.blue  = reading[2];
                want.fault = fault;
                expected_status.push_back(want);
            end
        end
        o_pending <= expected_status.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the color sensor white balance block
// Drives sample beats with balance and measurement commands over several
// window lengths, with random gaps and stalls on both streams and one long
// output hold-off; the checker predicts and compares every status beat.
// ----------------------------------------------------------------------------
module tb;
    import cswb_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 32;
    localparam int WATCHDOG      = 5000;
    localparam int PHASE_BEATS   = 90;
    localparam int LONG_WINDOW   = 128;

    typedef enum {IDLE_RANDOM, IDLE_SPARSE, IDLE_NONE} t_idle_mode;
    typedef enum {LVL_DENSITY, LVL_TOGGLE, LVL_HOLD, LVL_COIN} t_level_pattern;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [WIN_WIDTH-1:0] i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;

    int                   pending;
    int                   fail_count;
    int                   beats_sent    = 0;
    int                   quiet_cycles  = 0;
    bit                   hold_req      = 1'b0;
    t_idle_mode           idle_mode     = IDLE_RANDOM;

    always #10 i_clk = ~i_clk;

    color_sensor_white_balance DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cswb_status_checker status_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int draw_wait();
        case (idle_mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            default:     return $urandom_range(0, 16);
        endcase
    endfunction

    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic send_beat(input logic [1:0] act, input logic lvl);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, lvl, act};
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // Waits until every status beat is out and the divider has gone quiet.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_WIDTH-1:0] ticks);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One full pass from the start beat to its last window, with stray
    // commands mixed in that the busy block has to ignore.
    task automatic run_sequence(input logic [1:0] act, input int win,
                                input t_level_pattern pat);
        int   span;
        int   density;
        logic lvl;
        logic [1:0] stray;
        span    = ((win == 0) ? 1 : win) * ((act == ACT_BAL_MEAS) ? 6 : 3);
        density = $urandom_range(5, 95);
        lvl     = 1'($urandom_range(0, 1));
        send_beat(act, lvl);
        for (int i = 0; i < span; i++) begin
            case (pat)
                LVL_DENSITY: lvl = ($urandom_range(0, 99) < density);
                LVL_TOGGLE:  lvl = ~lvl;
                LVL_COIN:    lvl = 1'($urandom_range(0, 1));
                default:     lvl = lvl;
            endcase
            stray = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : ACT_NONE;
            send_beat(stray, lvl);
        end
    endtask

    initial begin : stimulus
        int win_plan [8];
        int phase_start;
        int win;
        win_plan = '{1, 2, 3, 5, 8, 12, 4, 7};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero window length, so every tick closes a window.
        write_window('0);
        send_beat(ACT_NONE, 1'b1);
        send_beat(ACT_NONE, 1'b0);
        send_beat(ACT_NONE, 1'b1);
        // Measuring before any balance finds every gain at zero.
        send_beat(ACT_MEASURE, 1'b1);
        send_beat(ACT_NONE, 1'b0);
        send_beat(ACT_NONE, 1'b1);
        send_beat(ACT_NONE, 1'b0);
        // Balance with a command arriving while busy.
        send_beat(ACT_BALANCE, 1'b1);
        send_beat(ACT_NONE, 1'b0);
        send_beat(ACT_BAL_MEAS, 1'b1);
        send_beat(ACT_NONE, 1'b0);
        // Balance chained straight into a measurement.
        send_beat(ACT_BAL_MEAS, 1'b1);
        send_beat(ACT_NONE, 1'b0);
        send_beat(ACT_NONE, 1'b0);
        send_beat(ACT_NONE, 1'b1);
        send_beat(ACT_MEASURE, 1'b0);
        send_beat(ACT_NONE, 1'b1);
        send_beat(ACT_NONE, 1'b1);
        settle_block();

        // A long window: one balance pass at full speed leaves large gains.
        idle_mode = IDLE_NONE;
        write_window(WIN_WIDTH'(LONG_WINDOW));
        run_sequence(ACT_BALANCE, LONG_WINDOW, LVL_TOGGLE);
        settle_block();

        for (int p = 0; p < 8; p++) begin
            win = (p >= 6) ? int'($urandom_range(1, 16)) : win_plan[p];
            write_window(WIN_WIDTH'(win));
            idle_mode = t_idle_mode'(p % 3);
            if (p == 4) begin
                idle_mode = IDLE_NONE;
                hold_req  = 1'b1;
            end
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                repeat ($urandom_range(0, 3)) send_beat(ACT_NONE, 1'($urandom_range(0, 1)));
                run_sequence(2'($urandom_range(1, 3)), win,
                             t_level_pattern'($urandom_range(0, 3)));
            end
            settle_block();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("color_sensor_white_balance test passed");
        end else begin
            $display("color_sensor_white_balance test failed");
        end
        $finish;
    end

    initial begin : status_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                // Long hold-off so the block backs up into its input.
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = draw_wait();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("color_sensor_white_balance test failed");
                $finish;
            end
        end
    end

endmodule
